// File: src/nfts_pkg.sv
// Shared types, codes and constants for the nearest free tile search block.
package nfts_pkg;

    // Default grid edge length and default search radius.
    localparam int GRID_DIM_DEFAULT = 64;
    localparam logic [4:0] RADIUS_RESET = 5'd16;
    localparam logic [6:0] DIM_RESET = 7'd64;

    // Field widths fixed by the interface.
    localparam int TILE_W   = 8;
    localparam int CFG_W    = 7;
    localparam int RADIUS_W = 5;
    localparam int STATUS_W = 2;

    // Probe coordinates need one bit more than a tile to hold tile +/- radius.
    typedef logic signed [TILE_W:0] coord_t;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_SEARCH_RADIUS = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_FREE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MOVED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd2;

    // Control states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_READ,
        ST_WR_WRITE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // One probe as produced by the ring sequencer.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   center;
        logic   last;
    } probe_t;

    // Commands from the top level to the ring sequencer.
    typedef struct packed {
        logic start;
        logic advance;
    } probe_ctl_t;

endpackage

// File: src/nfts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nfts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/nfts_probe_gen.sv
// Ring sequencer: walks the query tile, then Manhattan rings 1..radius in probe order.
module nfts_probe_gen
    import nfts_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  probe_ctl_t                  ctl,
    input  logic signed [TILE_W-1:0]    tx,
    input  logic signed [TILE_W-1:0]    ty,
    input  logic [RADIUS_W-1:0]         rmax,
    output probe_t                      probe
);

    logic                  center_reg, center_next;
    logic                  k_reg, k_next;
    logic [RADIUS_W-1:0]   r_reg, r_next;
    logic signed [RADIUS_W:0] dy_reg, dy_next;

    logic [RADIUS_W:0]     dy_abs;
    logic [RADIUS_W-1:0]   dx;
    coord_t                tx_ext, ty_ext, dx_ext, dy_ext;
    logic                  row_end;

    // Offsets of the current probe within its ring.
    always_comb
    begin
        dy_abs  = dy_reg[RADIUS_W] ? (RADIUS_W+1)'(-dy_reg) : dy_reg;
        dx      = r_reg - dy_abs[RADIUS_W-1:0];
        tx_ext  = {tx[TILE_W-1], tx};
        ty_ext  = {ty[TILE_W-1], ty};
        dx_ext  = {{(TILE_W+1-RADIUS_W){1'b0}}, dx};
        dy_ext  = {{(TILE_W-RADIUS_W){dy_reg[RADIUS_W]}}, dy_reg};
        row_end = (dy_reg == $signed({1'b0, r_reg}));
    end

    // Probe coordinates and the flag for the final probe of the search.
    always_comb
    begin
        probe.center = center_reg;
        if (center_reg)
        begin
            probe.x    = tx_ext;
            probe.y    = ty_ext;
            probe.last = (rmax == '0);
        end
        else
        begin
            probe.x    = k_reg ? tx_ext + dx_ext : tx_ext - dx_ext;
            probe.y    = ty_ext + dy_ext;
            probe.last = k_reg && row_end && (r_reg == rmax);
        end
    end

    // Step order: -dx then +dx, next row, next ring.
    always_comb
    begin
        center_next = center_reg;
        k_next      = k_reg;
        r_next      = r_reg;
        dy_next     = dy_reg;
        if (ctl.start)
        begin
            center_next = 1'b1;
            k_next      = 1'b0;
        end
        else if (ctl.advance)
        begin
            if (center_reg)
            begin
                center_next = 1'b0;
                r_next      = RADIUS_W'(1);
                dy_next     = '1;
                k_next      = 1'b0;
            end
            else if (!k_reg)
            begin
                k_next = 1'b1;
            end
            else
            begin
                k_next = 1'b0;
                if (row_end)
                begin
                    r_next  = r_reg + RADIUS_W'(1);
                    // Bitwise inverse of r is -(r+1), the first row of the next ring.
                    dy_next = ~{1'b0, r_reg};
                end
                else
                begin
                    dy_next = dy_reg + (RADIUS_W+1)'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= 1'b1;
            k_reg      <= 1'b0;
            r_reg      <= '0;
            dy_reg     <= '0;
        end
        else
        begin
            center_reg <= center_next;
            k_reg      <= k_next;
            r_reg      <= r_next;
            dy_reg     <= dy_next;
        end
    end

endmodule

// File: src/nearest_free_tile_search.sv
// Top level of the nearest free tile search: command handling, probe pipeline and result port.
//
// The blocking map lives in a RAM of GRID_DIM rows, each a GRID_DIM-bit row of tiles,
// with one valid flip-flop per row that reset clears, so the block is ready right after
// reset with no clearing pass. A write passes through accept, row read and row write back.
// A query probes one tile per cycle through the RAM read port, each probe evaluated in the
// cycle after the ring sequencer issues it: the query tile first, then 4r+2 probes for each
// ring r up to search_radius, stopping at the first free tile. The full search over R rings
// is P = 2R*R + 4R + 1 probes, which is 577 probes at the reset radius of 16. Configuration
// writes are taken at any time and are meant to arrive only while the block is idle. The
// finished result sits in an output register, so a new item is taken while the previous
// result waits on out_stall.
module nearest_free_tile_search
    import nfts_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic signed [TILE_W-1:0]   tile_x,
    input  logic signed [TILE_W-1:0]   tile_y,
    input  logic                       blocked,
    // Output channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [TILE_W-1:0]   found_x,
    output logic signed [TILE_W-1:0]   found_y,
    output logic [STATUS_W-1:0]        status,
    // Configuration write port.
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int ADDR_W = $clog2(GRID_DIM);
    localparam logic [TILE_W:0] DIM_EXT = (TILE_W+1)'(GRID_DIM);

    // Configuration registers.
    logic [CFG_W-1:0]    grid_width_reg, grid_height_reg;
    logic [RADIUS_W-1:0] search_radius_reg;
    logic [TILE_W:0]     eff_w, eff_h;

    // Control state and the held item.
    state_t                    state_reg, state_next;
    logic signed [TILE_W-1:0]  tx_reg, ty_reg;
    logic                      blocked_reg;
    logic                      issuing_reg, issuing_next;

    // Probe pipeline, one stage behind the RAM read.
    logic                      p_valid_reg, p_valid_next;
    coord_t                    p_x_reg, p_y_reg;
    logic                      p_inb_reg, p_center_reg, p_last_reg, p_rowvalid_reg;

    // Result waiting for the output register.
    logic signed [TILE_W-1:0]  res_x_reg, res_y_reg;
    logic [STATUS_W-1:0]       res_status_reg;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [TILE_W-1:0]  out_x_reg, out_y_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    // Row valid bits; a row never written reads as all free.
    logic [GRID_DIM-1:0]       row_valid_reg;

    // RAM connections.
    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_raddr, ram_waddr;
    logic [GRID_DIM-1:0]       ram_wdata, ram_rdata, row_old;

    // Miscellaneous control.
    probe_ctl_t                ctl;
    probe_t                    probe;
    logic                      accept, issue, probe_inb, w_inb, p_free, resolve, out_load;
    coord_t                    w_x, w_y;

    // Clamp the configured grid to the physical map.
    always_comb
    begin
        eff_w = ({2'b0, grid_width_reg} > DIM_EXT) ? DIM_EXT : {2'b0, grid_width_reg};
        eff_h = ({2'b0, grid_height_reg} > DIM_EXT) ? DIM_EXT : {2'b0, grid_height_reg};
    end

    // Bounds checks for the held write tile and the current probe.
    always_comb
    begin
        w_x       = {tx_reg[TILE_W-1], tx_reg};
        w_y       = {ty_reg[TILE_W-1], ty_reg};
        w_inb     = !w_x[TILE_W] && !w_y[TILE_W] &&
                    ($unsigned(w_x) < eff_w) && ($unsigned(w_y) < eff_h);
        probe_inb = !probe.x[TILE_W] && !probe.y[TILE_W] &&
                    ($unsigned(probe.x) < eff_w) && ($unsigned(probe.y) < eff_h);
    end

    // Evaluate the probe whose row arrived from the RAM this cycle.
    always_comb
    begin
        p_free   = p_inb_reg && !(p_rowvalid_reg && ram_rdata[p_x_reg[ADDR_W-1:0]]);
        resolve  = p_valid_reg && (p_free || p_last_reg);
        accept   = in_valid && !in_stall;
        issue    = (state_reg == ST_SEARCH) && issuing_reg;
        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == CMD_WRITE) ? ST_WR_READ : ST_SEARCH;
                end
            end
            ST_WR_READ:  state_next = ST_WR_WRITE;
            ST_WR_WRITE: state_next = ST_IDLE;
            ST_SEARCH:
            begin
                if (resolve)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // State outputs: handshake, RAM controls and sequencer commands.
    always_comb
    begin
        in_stall    = 1'b1;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = probe.y[ADDR_W-1:0];
        ctl.start   = 1'b0;
        ctl.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctl.start = in_valid && (command == CMD_QUERY);
            end
            ST_WR_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = w_y[ADDR_W-1:0];
            end
            ST_WR_WRITE:
            begin
                ram_we = w_inb;
            end
            ST_SEARCH:
            begin
                ram_re      = issue;
                ctl.advance = issue;
            end
            ST_FINISH:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Row update for a write: merge the new bit into the old row.
    always_comb
    begin
        ram_waddr = w_y[ADDR_W-1:0];
        row_old   = row_valid_reg[ram_waddr] ? ram_rdata : '0;
        ram_wdata = row_old;
        ram_wdata[w_x[ADDR_W-1:0]] = blocked_reg;
    end

    // Issue and pipeline bookkeeping.
    always_comb
    begin
        issuing_next = issuing_reg;
        if (ctl.start)
        begin
            issuing_next = 1'b1;
        end
        else if (issue && probe.last)
        begin
            issuing_next = 1'b0;
        end
        p_valid_next = issue && !resolve;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            issuing_reg       <= 1'b0;
            p_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            row_valid_reg     <= '0;
            grid_width_reg    <= DIM_RESET;
            grid_height_reg   <= DIM_RESET;
            search_radius_reg <= RADIUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            issuing_reg   <= issuing_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:    grid_width_reg    <= cfg_data;
                    REG_GRID_HEIGHT:   grid_height_reg   <= cfg_data;
                    REG_SEARCH_RADIUS: search_radius_reg <= cfg_data[RADIUS_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers: held item, probe stage, result and output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_reg      <= tile_x;
            ty_reg      <= tile_y;
            blocked_reg <= blocked;
        end
        if (issue)
        begin
            p_x_reg        <= probe.x;
            p_y_reg        <= probe.y;
            p_inb_reg      <= probe_inb;
            p_center_reg   <= probe.center;
            p_last_reg     <= probe.last;
            p_rowvalid_reg <= row_valid_reg[probe.y[ADDR_W-1:0]];
        end
        if ((state_reg == ST_SEARCH) && resolve)
        begin
            if (p_free)
            begin
                res_x_reg      <= p_x_reg[TILE_W-1:0];
                res_y_reg      <= p_y_reg[TILE_W-1:0];
                res_status_reg <= p_center_reg ? STAT_FREE : STAT_MOVED;
            end
            else
            begin
                res_x_reg      <= tx_reg;
                res_y_reg      <= ty_reg;
                res_status_reg <= STAT_NONE;
            end
        end
        if (out_load)
        begin
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found_x   = out_x_reg;
    assign found_y   = out_y_reg;
    assign status    = out_status_reg;

    // Ring sequencer.
    nfts_probe_gen u_probe_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .tx    (tx_reg),
        .ty    (ty_reg),
        .rmax  (search_radius_reg),
        .probe (probe)
    );

    // Blocking map, one row of tiles per entry.
    nfts_ram #(
        .WIDTH (GRID_DIM),
        .DEPTH (GRID_DIM)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A probe in flight always comes from a cycle spent searching.
    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg) == ST_SEARCH)
        else $error("probe stage valid outside a search");

    // A map write never overlaps a probe read still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !p_valid_reg && !issuing_reg || state_reg == ST_WR_WRITE)
        else $error("map write during a search");

    // The finish state is only entered from a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_FINISH) |-> $past(state_reg) == ST_SEARCH)
        else $error("result produced without a search");

    // A loaded result never carries an undefined status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> status == STAT_FREE || status == STAT_MOVED || status == STAT_NONE)
        else $error("bad status code loaded");

endmodule

// File: sim/nearest_free_tile_search_test.sv
// Self-checking testbench for the nearest free tile search block.
`timescale 1ns / 1ps

module nearest_free_tile_search_test;
    import nfts_pkg::*;

    localparam int GRID_DIM      = GRID_DIM_DEFAULT;
    // Wait after the last write; it covers a write's accept, row read and write back with margin.
    localparam int WRITE_SETTLE  = 8;
    localparam int END_QUIET     = 20;
    // Worst case is far below this: every query a full search plus long stalls.
    localparam int CYCLE_LIMIT   = 4_000_000;

    typedef logic signed [TILE_W-1:0] tile_t;

    typedef struct {
        tile_t               found_x;
        tile_t               found_y;
        logic [STATUS_W-1:0] status;
    } tile_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    tile_t                 tile_x;
    tile_t                 tile_y;
    logic                  blocked;
    logic                  out_valid;
    logic                  out_stall;
    tile_t                 found_x;
    tile_t                 found_y;
    logic [STATUS_W-1:0]   status;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // Shadow copy of the block's map and registers.
    bit                    blocking_map [GRID_DIM*GRID_DIM];
    logic [CFG_W-1:0]      grid_width_cfg;
    logic [CFG_W-1:0]      grid_height_cfg;
    logic [RADIUS_W-1:0]   search_radius_cfg;

    tile_result_t          pending_results[$];
    int                    item_count;
    int                    fail_count;
    int                    cycle_count;
    bit                    idle_on;

    nearest_free_tile_search #(.GRID_DIM(GRID_DIM)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .tile_x    (tile_x),
        .tile_y    (tile_y),
        .blocked   (blocked),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found_x   (found_x),
        .found_y   (found_y),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Grid sizes above the array edge are clipped to it.
    function automatic int eff_dim(logic [CFG_W-1:0] v);
        return (v > GRID_DIM) ? GRID_DIM : int'(v);
    endfunction

    function automatic bit tile_in_grid(int x, int y);
        return x >= 0 && y >= 0 && x < eff_dim(grid_width_cfg) && y < eff_dim(grid_height_cfg);
    endfunction

    // Tiles outside the grid in use always block.
    function automatic bit tile_blocks(int x, int y);
        if (!tile_in_grid(x, y))
            return 1'b1;
        return blocking_map[y*GRID_DIM + x];
    endfunction

    // Ring search: own tile, then rings 1..radius, rows top to bottom, left before right.
    function automatic tile_result_t find_free_tile(tile_t qx, tile_t qy);
        tile_result_t res;
        int           tx;
        int           ty;
        int           r;
        int           dy;
        int           dx;
        int           k;
        int           x;
        bit           done;
        tx = qx;
        ty = qy;
        res.found_x = qx;
        res.found_y = qy;
        res.status  = STAT_NONE;
        done        = 1'b0;
        if (!tile_blocks(tx, ty))
        begin
            res.status = STAT_FREE;
            return res;
        end
        for (r = 1; r <= int'(search_radius_cfg) && !done; r++)
        begin
            for (dy = -r; dy <= r && !done; dy++)
            begin
                dx = r - ((dy < 0) ? -dy : dy);
                for (k = 0; k < 2 && !done; k++)
                begin
                    x = (k == 0) ? tx - dx : tx + dx;
                    if (!tile_blocks(x, ty + dy))
                    begin
                        res.found_x = x[TILE_W-1:0];
                        res.found_y = tile_t'(ty + dy);
                        res.status  = STAT_MOVED;
                        done        = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // Update the shadow state for one accepted transfer.
    task automatic apply_item(logic cmd, tile_t x, tile_t y, logic blk);
        int ix;
        int iy;
        ix = x;
        iy = y;
        if (cmd == CMD_WRITE)
        begin
            if (tile_in_grid(ix, iy))
            begin
                blocking_map[iy*GRID_DIM + ix] = blk;
            end
        end
        else
        begin
            pending_results.push_back(find_free_tile(x, y));
        end
        item_count++;
    endtask

    // Mostly short gaps, a few long ones, none when idling is off.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Offer one item on the input channel and wait for its transfer.
    task automatic send_item(logic cmd, int x, int y, logic blk);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        tile_x   <= x[TILE_W-1:0];
        tile_y   <= y[TILE_W-1:0];
        blocked  <= blk;
        do
            @(posedge clk);
        while (in_stall);
        apply_item(cmd, x[TILE_W-1:0], y[TILE_W-1:0], blk);
    endtask

    // Hold off the sender until every query has answered and the last write settled.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (WRITE_SETTLE) @(posedge clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_config(logic [1:0] idx, int val);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:    grid_width_cfg    = val[CFG_W-1:0];
            REG_GRID_HEIGHT:   grid_height_cfg   = val[CFG_W-1:0];
            REG_SEARCH_RADIUS: search_radius_cfg = val[RADIUS_W-1:0];
            default:           ;
        endcase
    endtask

    function automatic int rand_offset(int s);
        return int'($urandom_range(0, 2*s)) - s;
    endfunction

    // Coordinate inside the grid in use, or anywhere when the grid is empty.
    function automatic int rand_coord(int dim);
        if (dim > 0)
            return $urandom_range(0, dim - 1);
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    // Free tile at reset, then blocked tiles at two grid corners.
    task automatic test_default_grid();
        send_item(CMD_QUERY, 0, 0, 1'b0);
        send_item(CMD_WRITE, 0, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 1'b0);
        send_item(CMD_WRITE, 63, 63, 1'b1);
        send_item(CMD_QUERY, 63, 63, 1'b0);
    endtask

    // Writes outside the grid are dropped; queries outside it search inward or fail.
    task automatic test_out_of_bounds();
        send_item(CMD_WRITE, 64, 5, 1'b1);
        send_item(CMD_WRITE, -1, -1, 1'b1);
        send_item(CMD_WRITE, 127, 127, 1'b1);
        send_item(CMD_WRITE, -128, -128, 1'b1);
        send_item(CMD_QUERY, 64, 5, 1'b0);
        send_item(CMD_QUERY, -128, -128, 1'b0);
        send_item(CMD_QUERY, 127, 127, 1'b0);
    endtask

    // Centre column probed twice, and a tile blocked then freed again.
    task automatic test_centre_column_and_clear();
        send_item(CMD_WRITE, 20, 20, 1'b1);
        send_item(CMD_WRITE, 20, 19, 1'b1);
        send_item(CMD_QUERY, 20, 20, 1'b0);
        send_item(CMD_WRITE, 10, 10, 1'b1);
        send_item(CMD_WRITE, 10, 10, 1'b0);
        send_item(CMD_QUERY, 10, 10, 1'b0);
    endtask

    // One-tile grid with radius zero, then an empty grid.
    task automatic test_tiny_and_empty_grid();
        write_config(REG_GRID_WIDTH, 1);
        write_config(REG_GRID_HEIGHT, 1);
        write_config(REG_SEARCH_RADIUS, 0);
        send_item(CMD_QUERY, 0, 0, 1'b0);
        send_item(CMD_WRITE, 0, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 1'b0);
        write_config(REG_GRID_WIDTH, 0);
        write_config(REG_SEARCH_RADIUS, 5);
        send_item(CMD_QUERY, 0, 0, 1'b0);
    endtask

    // Oversized grid is clipped; the old blocking bit at the origin is still there.
    task automatic test_oversized_and_stale();
        write_config(REG_GRID_WIDTH, 127);
        write_config(REG_GRID_HEIGHT, 65);
        write_config(REG_SEARCH_RADIUS, 31);
        send_item(CMD_QUERY, 0, 0, 1'b0);
        send_item(CMD_WRITE, 64, 0, 1'b1);
        send_item(CMD_QUERY, 63, 0, 1'b0);
        send_item(CMD_QUERY, -128, -128, 1'b0);
    endtask

    // Random traffic under one setting: mostly blocked clusters followed by a query nearby.
    task automatic test_random_traffic(int width, int height, int radius, bit idling,
                                       int n_items);
        int target;
        int ew;
        int eh;
        int cx;
        int cy;
        int roll;
        int spread;
        int i;
        int dy;
        int dx;
        write_config(REG_GRID_WIDTH, width);
        write_config(REG_GRID_HEIGHT, height);
        write_config(REG_SEARCH_RADIUS, (radius & 31) | (int'($urandom_range(0, 3)) << 5));
        idle_on = idling;
        ew      = eff_dim(grid_width_cfg);
        eh      = eff_dim(grid_height_cfg);
        target  = item_count + n_items;
        while (item_count < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                cx     = rand_coord(ew);
                cy     = rand_coord(eh);
                spread = $urandom_range(1, 3);
                if ($urandom_range(0, 5) == 0)
                begin
                    // Fill a whole diamond so the search must go past it.
                    for (dy = -spread; dy <= spread; dy++)
                        for (dx = -(spread - ((dy < 0) ? -dy : dy));
                             dx <= spread - ((dy < 0) ? -dy : dy); dx++)
                            send_item(CMD_WRITE, cx + dx, cy + dy, 1'b1);
                end
                else
                begin
                    for (i = $urandom_range(0, 12); i > 0; i--)
                        send_item(CMD_WRITE, cx + rand_offset(spread), cy + rand_offset(spread),
                                  $urandom_range(0, 9) < 8);
                end
                send_item(CMD_QUERY, cx + rand_offset(1), cy + rand_offset(1), 1'b0);
            end
            else if (roll < 75)
                send_item(CMD_WRITE, rand_coord(ew), rand_coord(eh), 1'($urandom_range(0, 1)));
            else if (roll < 85)
                send_item(CMD_QUERY, rand_coord(ew), rand_coord(eh), 1'($urandom_range(0, 1)));
            else if (roll < 98)
                send_item(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                          $urandom_range(0, 255), 1'($urandom_range(0, 1)));
            else
                drain_results();
        end
        idle_on = 1'b1;
    endtask

    // Receiver stall pattern: runs of ready, short stalls, now and then a long one; none when idling is off.
    initial
    begin : stall_gen
        int run_left;
        out_stall = 1'b0;
        run_left  = 0;
        forever
        begin
            @(negedge clk);
            if (run_left > 0)
                run_left--;
            else if (!idle_on || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                run_left  = $urandom_range(0, 15);
            end
            else
            begin
                out_stall <= 1'b1;
                run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
            end
        end
    end

    // Compare every output transfer against the oldest expected result.
    always @(posedge clk)
    begin : check_results
        tile_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no query outstanding: found_x %0d found_y %0d status %0d",
                       found_x, found_y, status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found_x !== want.found_x)
                begin
                    $error("found_x mismatch: expected %0d, actual %0d", want.found_x, found_x);
                    fail_count++;
                end
                if (found_y !== want.found_y)
                begin
                    $error("found_y mismatch: expected %0d, actual %0d", want.found_y, found_y);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    // Run-length guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nearest_free_tile_search test failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        in_valid          = 1'b0;
        command           = CMD_WRITE;
        tile_x            = '0;
        tile_y            = '0;
        blocked           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_GRID_WIDTH;
        cfg_data          = '0;
        rst_n             = 1'b0;
        grid_width_cfg    = DIM_RESET;
        grid_height_cfg   = DIM_RESET;
        search_radius_cfg = RADIUS_RESET;
        item_count        = 0;
        fail_count        = 0;
        cycle_count       = 0;
        idle_on           = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_grid();
        test_out_of_bounds();
        test_centre_column_and_clear();
        test_tiny_and_empty_grid();
        test_oversized_and_stale();

        test_random_traffic(64, 64, 16, 1'b1, 90);
        test_random_traffic(8, 8, 4, 1'b1, 70);
        test_random_traffic(64, 64, 2, 1'b0, 60);
        test_random_traffic(13, 7, 6, 1'b1, 70);
        test_random_traffic(127, 100, 31, 1'b1, 60);
        test_random_traffic(0, 9, 3, 1'b1, 30);
        test_random_traffic(64, 1, 5, 1'b1, 60);
        test_random_traffic(1, 64, 7, 1'b0, 60);

        drain_results();
        repeat (END_QUIET) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("nearest_free_tile_search test passed");
        else
            $display("nearest_free_tile_search test failed");
        $finish;
    end

endmodule
